@@ rtl/ffa_pkg.sv @@
// ---------------------------------------------------------------------------
// ffa_pkg: shared types and constants
// Codes, defaults and the command and status bundles between controller and
// datapath of the first-fit aligned free-list allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

  // default sizes
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int ADDR_BITS_DEF    = 32;

  // request modes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_WHOLE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_FIT    = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // configuration register indexes
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  // segment store write data source
  typedef enum logic [2:0] {
    WS_SHIFT,
    WS_PAD,
    WS_BACK,
    WS_WHOLE,
    WS_TOT,
    WS_PREV,
    WS_NEXT,
    WS_NEW
  } ws_e;

  // segment store write address source
  typedef enum logic [2:0] {
    AS_IDX,
    AS_IDX1,
    AS_IDXM1,
    AS_K,
    AS_ZERO
  } as_e;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_en;
    logic       rd_shift;
    logic       div_start;
    logic       calc_pad;
    logic       calc_lp;
    logic       calc_fit;
    logic       calc_send;
    logic       save_prev;
    logic       save_next;
    logic       calc_j1;
    logic       calc_j2;
    logic       k_load_open;
    logic       k_load_close;
    logic       k_step;
    logic       wr_en;
    ws_e        wr_src;
    as_e        wr_addr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_one;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_grant;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       too_large;
    logic       size_zero;
    logic       idx_lt_count;
    logic       full;
    logic       rd_le;
    logic       fits;
    logic       pad_nz;
    logic       back_nz;
    logic       join_prev;
    logic       join_next;
    logic       shift_more;
    logic       div_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/first_fit_aligned_free_list_allocator_top.sv @@
// ---------------------------------------------------------------------------
// first_fit_aligned_free_list_allocator_top: first-fit aligned allocator
// Keeps an address-ordered list of free segments and serves allocate, free
// and reset-to-whole-range transactions, one result per transaction.
// ---------------------------------------------------------------------------
// One transaction is worked on at a time. An allocate visits the segments
// in order and takes the remainder of each segment start by the alignment
// from a bit-serial divider; each entry moved when a split opens a slot or
// an exact fit closes one is read and then written. A free walks the
// segments through the one read port of the segment memory, merges, and
// moves entries by a read and a write each. A reset-to-whole-range
// transaction writes entry zero. The next transaction is taken while the
// last result still waits on the output.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_aligned_free_list_allocator_top #(
  parameter int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ffa_pkg::ADDR_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] request_size, [63:32] alignment, [95:64] block_offset
  input  wire logic [95:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] result_offset, [63:32] result_size
  output logic [63:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]       m_axis_tuser,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int AW = ADDR_BITS;

  logic [31:0]   base_q, rsize_q;
  logic [63:0]   size_w, align_w, boff_w, base_w, rsize_w;
  logic [63:0]   off_w, gr_w;
  logic [AW-1:0] res_off, res_gr;
  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      rsize_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        ffa_pkg::REG_BASE: base_q  <= pwdata;
        default:           rsize_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ffa_pkg::REG_BASE: prdata = base_q;
      default:           prdata = rsize_q;
    endcase
  end

  // fit 32-bit fields to the address width
  assign size_w  = 64'(s_axis_tdata[31:0]);
  assign align_w = 64'(s_axis_tdata[63:32]);
  assign boff_w  = 64'(s_axis_tdata[95:64]);
  assign base_w  = 64'(base_q);
  assign rsize_w = 64'(rsize_q);
  assign off_w   = 64'(res_off);
  assign gr_w    = 64'(res_gr);

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .AW           (AW)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .mode_i    (s_axis_tuser),
    .size_i    (size_w[AW-1:0]),
    .align_i   (align_w[AW-1:0]),
    .boff_i    (boff_w[AW-1:0]),
    .base_i    (base_w[AW-1:0]),
    .rsize_i   (rsize_w[AW-1:0]),
    .status_o  (m_axis_tuser),
    .offset_o  (res_off),
    .granted_o (res_gr)
  );

  assign m_axis_tdata = {gr_w[31:0], off_w[31:0]};

endmodule
`default_nettype wire

@@ rtl/ffa_rem.sv @@
// ---------------------------------------------------------------------------
// ffa_rem: remainder unit
// Restoring division, one quotient bit per cycle, remainder only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffa_rem #(
  parameter int AW = ffa_pkg::ADDR_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [AW-1:0] dividend_i,
  input  wire logic [AW-1:0] divisor_i,
  output logic               busy_o,
  output logic [AW-1:0]      rem_o
);
  localparam int SW = $clog2(AW + 1);

  logic [AW-1:0] rem_q, rem_d;
  logic [AW-1:0] dvd_q, dvd_d;
  logic [AW-1:0] den_q;
  logic [SW-1:0] step_q, step_d;
  logic          busy_q, busy_d;
  logic [AW:0]   trial;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q, dvd_q[AW-1]};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      step_d = SW'(AW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = AW'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[AW-1:0];
      end
      dvd_d  = {dvd_q[AW-2:0], 1'b0};
      step_d = step_q - SW'(1);
      busy_d = (step_q != SW'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ rtl/ffa_datapath.sv @@
// ---------------------------------------------------------------------------
// ffa_datapath: segment store and arithmetic
// Holds the segment memory, the request registers, the walk and shift
// counters, the remainder unit and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffa_datapath #(
  parameter int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS_DEF,
  parameter int AW           = ffa_pkg::ADDR_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  ffa_pkg::cmd_t      cmd_i,
  output ffa_pkg::sts_t      sts_o,
  input  wire logic [1:0]    mode_i,
  input  wire logic [AW-1:0] size_i,
  input  wire logic [AW-1:0] align_i,
  input  wire logic [AW-1:0] boff_i,
  input  wire logic [AW-1:0] base_i,
  input  wire logic [AW-1:0] rsize_i,
  output logic [1:0]         status_o,
  output logic [AW-1:0]      offset_o,
  output logic [AW-1:0]      granted_o
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic [AW-1:0] mem_s [MAX_SEGMENTS];
  logic [AW-1:0] mem_l [MAX_SEGMENTS];

  logic [1:0]    mode_q;
  logic [AW-1:0] size_q, align_q, boff_q;
  logic [AW-1:0] seg_s_q, seg_l_q, prev_s_q, prev_l_q;
  logic [AW-1:0] pad_q, lp_q, s_q, back_q, send_q;
  logic [AW-1:0] end_q, psum_q, nsum_q, pend_q, tot_q;
  logic          padgt_q, jp_q, jn_q;
  logic [CW-1:0] idx_q, k_q, count_q;
  logic          open_q, e0v_q, rd_zero_q;
  logic [AW-1:0] rd_s_q, rd_l_q, rd_s, rd_l;
  logic [1:0]    out_st_q;
  logic [AW-1:0] out_off_q, out_size_q;

  logic [AW-1:0] den, div_rem;
  logic          div_busy;
  logic [CW-1:0] ra_full, wa_full;
  logic [IW-1:0] ra, wa;
  logic [AW-1:0] wd_s, wd_l;

  // zero alignment acts as one
  assign den = (align_q == '0) ? AW'(1) : align_q;

  ffa_rem #(.AW(AW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_s),
    .divisor_i  (den),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // entry zero reads as empty until first written after reset
  assign rd_s = rd_zero_q ? '0 : rd_s_q;
  assign rd_l = rd_zero_q ? '0 : rd_l_q;

  // read address
  always_comb begin
    if (!cmd_i.rd_shift) begin
      ra_full = idx_q;
    end else if (open_q) begin
      ra_full = k_q - CW'(1);
    end else begin
      ra_full = k_q + CW'(1);
    end
    ra = ra_full[IW-1:0];
  end

  // write address and data
  always_comb begin
    case (cmd_i.wr_addr)
      ffa_pkg::AS_IDX:   wa_full = idx_q;
      ffa_pkg::AS_IDX1:  wa_full = idx_q + CW'(1);
      ffa_pkg::AS_IDXM1: wa_full = idx_q - CW'(1);
      ffa_pkg::AS_K:     wa_full = k_q;
      default:           wa_full = '0;
    endcase
    wa = wa_full[IW-1:0];
    case (cmd_i.wr_src)
      ffa_pkg::WS_SHIFT: begin wd_s = rd_s;     wd_l = rd_l;     end
      ffa_pkg::WS_PAD:   begin wd_s = seg_s_q;  wd_l = pad_q;    end
      ffa_pkg::WS_BACK:  begin wd_s = send_q;   wd_l = back_q;   end
      ffa_pkg::WS_WHOLE: begin wd_s = base_i;   wd_l = rsize_i;  end
      ffa_pkg::WS_TOT:   begin wd_s = prev_s_q; wd_l = tot_q;    end
      ffa_pkg::WS_PREV:  begin wd_s = prev_s_q; wd_l = psum_q;   end
      ffa_pkg::WS_NEXT:  begin wd_s = boff_q;   wd_l = nsum_q;   end
      default:           begin wd_s = boff_q;   wd_l = size_q;   end
    endcase
  end

  // segment memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_s[wa] <= wd_s;
      mem_l[wa] <= wd_l;
    end
    if (cmd_i.rd_en) begin
      rd_s_q <= mem_s[ra];
      rd_l_q <= mem_l[ra];
    end
  end

  // counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      k_q       <= '0;
      open_q    <= 1'b0;
      count_q   <= CW'(1);
      e0v_q     <= 1'b1;
      rd_zero_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.k_load_open) begin
        k_q    <= count_q;
        open_q <= 1'b1;
      end else if (cmd_i.k_load_close) begin
        k_q    <= idx_q;
        open_q <= 1'b0;
      end else if (cmd_i.k_step) begin
        k_q <= open_q ? (k_q - CW'(1)) : (k_q + CW'(1));
      end
      if (cmd_i.cnt_one) begin
        count_q <= CW'(1);
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.wr_en && (wa == '0)) begin
        e0v_q <= 1'b0;
      end
      if (cmd_i.rd_en) begin
        rd_zero_q <= e0v_q && (ra == '0);
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q  <= mode_i;
      size_q  <= size_i;
      align_q <= align_i;
      boff_q  <= boff_i;
    end
    if (cmd_i.save_next) begin
      seg_s_q <= rd_s;
      seg_l_q <= rd_l;
    end
    if (cmd_i.save_prev) begin
      prev_s_q <= rd_s;
      prev_l_q <= rd_l;
    end
    if (cmd_i.calc_pad) begin
      pad_q <= (div_rem != '0) ? (den - div_rem) : '0;
    end
    if (cmd_i.calc_lp) begin
      lp_q    <= seg_l_q - pad_q;
      padgt_q <= pad_q > seg_l_q;
    end
    if (cmd_i.calc_fit) begin
      s_q    <= seg_s_q + pad_q;
      back_q <= lp_q - size_q;
    end
    if (cmd_i.calc_send) begin
      send_q <= s_q + size_q;
    end
    if (cmd_i.calc_j1) begin
      end_q  <= boff_q + size_q;
      psum_q <= prev_l_q + size_q;
      nsum_q <= seg_l_q + size_q;
      pend_q <= prev_s_q + prev_l_q;
    end
    if (cmd_i.calc_j2) begin
      jp_q  <= (idx_q != '0) && (pend_q == boff_q);
      jn_q  <= (idx_q < count_q) && (seg_s_q == end_q);
      tot_q <= psum_q + seg_l_q;
    end
    if (cmd_i.res_load) begin
      out_st_q   <= cmd_i.res_status;
      out_off_q  <= cmd_i.res_grant ? s_q : '0;
      out_size_q <= cmd_i.res_grant ? size_q : '0;
    end
  end

  // status toward the controller
  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.too_large    = size_q > rsize_i;
    sts_o.size_zero    = (size_q == '0);
    sts_o.idx_lt_count = idx_q < count_q;
    sts_o.full         = (count_q == CW'(MAX_SEGMENTS));
    sts_o.rd_le        = rd_s <= boff_q;
    sts_o.fits         = !padgt_q && (size_q <= lp_q);
    sts_o.pad_nz       = (pad_q != '0);
    sts_o.back_nz      = (back_q != '0);
    sts_o.join_prev    = jp_q;
    sts_o.join_next    = jn_q;
    sts_o.shift_more   = open_q ? (k_q > idx_q)
                                : ({1'b0, k_q} + (CW+1)'(1) < {1'b0, count_q});
    sts_o.div_busy     = div_busy;
  end

  assign status_o  = out_st_q;
  assign offset_o  = out_off_q;
  assign granted_o = out_size_q;

  // store occupancy stays within bounds
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SEGMENTS))
    else $error("segment count above store depth");

  a_no_grow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (count_q != CW'(MAX_SEGMENTS)))
    else $error("segment added to a full store");

  a_no_shrink_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (count_q != '0))
    else $error("segment removed from an empty store");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(div_busy) |-> (div_rem < den))
    else $error("remainder not below divisor");

endmodule
`default_nettype wire

@@ rtl/ffa_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffa_ctrl: request sequencer
// Walks the segment list, steers splits, merges and entry shifts, and
// owns the input and result handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffa_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::cmd_t cmd_o
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_A_RD   = 5'd2;
  localparam logic [4:0] S_A_WAIT = 5'd3;
  localparam logic [4:0] S_A_DIV  = 5'd4;
  localparam logic [4:0] S_A_PAD  = 5'd5;
  localparam logic [4:0] S_A_FIT  = 5'd6;
  localparam logic [4:0] S_A_EVAL = 5'd7;
  localparam logic [4:0] S_A_SEND = 5'd8;
  localparam logic [4:0] S_A_SPL  = 5'd9;
  localparam logic [4:0] S_F_RD   = 5'd10;
  localparam logic [4:0] S_F_WAIT = 5'd11;
  localparam logic [4:0] S_F_J1   = 5'd12;
  localparam logic [4:0] S_F_J2   = 5'd13;
  localparam logic [4:0] S_F_ACT  = 5'd14;
  localparam logic [4:0] S_SH_RD  = 5'd15;
  localparam logic [4:0] S_SH_WR  = 5'd16;
  localparam logic [4:0] S_FIN    = 5'd17;
  localparam logic [4:0] S_W2     = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  // work left after an entry shift
  localparam logic [1:0] P_SPLIT = 2'd0;
  localparam logic [1:0] P_CLOSE = 2'd1;
  localparam logic [1:0] P_NEW   = 2'd2;

  logic [4:0] state_q, state_d;
  logic [1:0] post_q, post_d;
  logic [1:0] st_q, st_d;
  logic       grant_q, grant_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    post_d      = post_q;
    st_d        = st_q;
    grant_d     = grant_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.wr_src  = ffa_pkg::WS_SHIFT;
    cmd_o.wr_addr = ffa_pkg::AS_IDX;
    cmd_o.res_status = st_q;
    cmd_o.res_grant  = grant_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.latch = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        st_d    = ffa_pkg::ST_OK;
        grant_d = 1'b0;
        case (sts_i.mode)
          ffa_pkg::MODE_ALLOC: begin
            if (sts_i.too_large) begin
              st_d    = ffa_pkg::ST_TOO_LARGE;
              state_d = S_DONE;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d = S_A_RD;
            end
          end
          ffa_pkg::MODE_FREE: begin
            if (sts_i.size_zero) begin
              state_d = S_DONE;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d = S_F_RD;
            end
          end
          ffa_pkg::MODE_WHOLE: begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_src  = ffa_pkg::WS_WHOLE;
            cmd_o.wr_addr = ffa_pkg::AS_ZERO;
            cmd_o.cnt_one = 1'b1;
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      // allocate: first-fit walk
      S_A_RD: begin
        if (sts_i.idx_lt_count) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_A_WAIT;
        end else begin
          st_d    = ffa_pkg::ST_NO_FIT;
          state_d = S_DONE;
        end
      end
      S_A_WAIT: begin
        cmd_o.save_next = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = S_A_DIV;
      end
      S_A_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = S_A_PAD;
        end
      end
      S_A_PAD: begin
        cmd_o.calc_pad = 1'b1;
        state_d = S_A_FIT;
      end
      S_A_FIT: begin
        cmd_o.calc_lp = 1'b1;
        state_d = S_A_EVAL;
      end
      S_A_EVAL: begin
        if (sts_i.fits) begin
          cmd_o.calc_fit = 1'b1;
          state_d = S_A_SEND;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_A_RD;
        end
      end
      S_A_SEND: begin
        cmd_o.calc_send = 1'b1;
        state_d = S_A_SPL;
      end
      S_A_SPL: begin
        if (sts_i.pad_nz && sts_i.back_nz) begin
          if (sts_i.full) begin
            st_d    = ffa_pkg::ST_FULL;
            state_d = S_DONE;
          end else begin
            cmd_o.k_load_open = 1'b1;
            post_d  = P_SPLIT;
            state_d = S_SH_RD;
          end
        end else if (sts_i.pad_nz) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = ffa_pkg::WS_PAD;
          grant_d = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.back_nz) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = ffa_pkg::WS_BACK;
          grant_d = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.k_load_close = 1'b1;
          post_d  = P_CLOSE;
          grant_d = 1'b1;
          state_d = S_SH_RD;
        end
      end
      // free: find insertion point
      S_F_RD: begin
        if (sts_i.idx_lt_count) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_F_WAIT;
        end else begin
          state_d = S_F_J1;
        end
      end
      S_F_WAIT: begin
        if (sts_i.rd_le) begin
          cmd_o.save_prev = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d = S_F_RD;
        end else begin
          cmd_o.save_next = 1'b1;
          state_d = S_F_J1;
        end
      end
      S_F_J1: begin
        cmd_o.calc_j1 = 1'b1;
        state_d = S_F_J2;
      end
      S_F_J2: begin
        cmd_o.calc_j2 = 1'b1;
        state_d = S_F_ACT;
      end
      S_F_ACT: begin
        if (sts_i.join_prev && sts_i.join_next) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_src  = ffa_pkg::WS_TOT;
          cmd_o.wr_addr = ffa_pkg::AS_IDXM1;
          cmd_o.k_load_close = 1'b1;
          post_d  = P_CLOSE;
          state_d = S_SH_RD;
        end else if (sts_i.join_prev) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_src  = ffa_pkg::WS_PREV;
          cmd_o.wr_addr = ffa_pkg::AS_IDXM1;
          state_d = S_DONE;
        end else if (sts_i.join_next) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = ffa_pkg::WS_NEXT;
          state_d = S_DONE;
        end else if (sts_i.full) begin
          st_d    = ffa_pkg::ST_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.k_load_open = 1'b1;
          post_d  = P_NEW;
          state_d = S_SH_RD;
        end
      end
      // move entries one place, each read and then written
      S_SH_RD: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_shift = 1'b1;
          state_d = S_SH_WR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = ffa_pkg::WS_SHIFT;
        cmd_o.wr_addr = ffa_pkg::AS_K;
        cmd_o.k_step  = 1'b1;
        state_d = S_SH_RD;
      end
      S_FIN: begin
        case (post_q)
          P_SPLIT: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_src = ffa_pkg::WS_PAD;
            state_d = S_W2;
          end
          P_CLOSE: begin
            cmd_o.cnt_dec = 1'b1;
            state_d = S_DONE;
          end
          default: begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_src  = ffa_pkg::WS_NEW;
            cmd_o.cnt_inc = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_W2: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = ffa_pkg::WS_BACK;
        cmd_o.wr_addr = ffa_pkg::AS_IDX1;
        cmd_o.cnt_inc = 1'b1;
        grant_d = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      post_q      <= P_SPLIT;
      st_q        <= ffa_pkg::ST_OK;
      grant_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      post_q      <= post_d;
      st_q        <= st_d;
      grant_q     <= grant_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result is only loaded into a free or draining output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.res_load && out_valid_q) |-> out_ready_i)
    else $error("pending result overwritten");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load && cmd_o.res_grant |-> (cmd_o.res_status == ffa_pkg::ST_OK))
    else $error("grant with error status");

  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_DISP))
    else $error("accepted transaction not dispatched");

endmodule
`default_nettype wire

@@ tb/first_fit_aligned_free_list_allocator_top_tb.sv @@
// ---------------------------------------------------------------------------
// first_fit_aligned_free_list_allocator_top_tb: allocator testbench
// Drives allocate, free, whole-range and unused-mode requests with random
// idle gaps on both streams and predicts every result from a local segment list model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module first_fit_aligned_free_list_allocator_top_tb;

  localparam int         SEGS        = 64;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_BASE   = {ffa_pkg::REG_BASE, 2'b00};
  localparam logic [2:0] ADDR_SIZE   = {ffa_pkg::REG_SIZE, 2'b00};
  localparam longint     CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [31:0] size;
  } grant_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
  } block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted allocator state
  logic [31:0] region_base_q, region_size_q;
  logic [31:0] seg_start [SEGS];
  logic [31:0] seg_len [SEGS];
  int          seg_count;

  grant_t expected_grants[$];
  block_t live_blocks[$];
  int     errors = 0;
  longint cycles = 0;

  first_fit_aligned_free_list_allocator_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // run-length guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // result side stalls
  initial begin : result_stall
    int stall;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        stall = gap_len();
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    grant_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]};
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                   got.status);
        if (got.offset !== want.offset)
          $display("%0t: offset expected %h actual %h", $realtime, want.offset,
                   got.offset);
        if (got.size !== want.size)
          $display("%0t: size expected %h actual %h", $realtime, want.size, got.size);
        if (got !== want) errors++;
      end
    end
  end

  // segment list helpers
  function automatic void open_slot(int at);
    for (int k = seg_count; k > at; k--) begin
      seg_start[k] = seg_start[k-1];
      seg_len[k]   = seg_len[k-1];
    end
    seg_count++;
  endfunction

  function automatic void close_slot(int at);
    for (int k = at; k + 1 < seg_count; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_len[k]   = seg_len[k+1];
    end
    seg_count--;
  endfunction

  function automatic grant_t first_fit(logic [31:0] size, logic [31:0] align_in);
    grant_t      g;
    logic [31:0] align, off, len, rem, pad, s, back;
    g = '0;
    if (size > region_size_q) begin
      g.status = ffa_pkg::ST_TOO_LARGE;
      return g;
    end
    align = (align_in == 0) ? 32'd1 : align_in;
    for (int i = 0; i < seg_count; i++) begin
      off = seg_start[i];
      len = seg_len[i];
      rem = off % align;
      pad = (rem != 0) ? align - rem : 32'd0;
      if (pad > len || size > len - pad) continue;
      s    = off + pad;
      back = len - pad - size;
      if (pad != 0 && back != 0) begin
        if (seg_count >= SEGS) begin
          g.status = ffa_pkg::ST_FULL;
          return g;
        end
        open_slot(i);
        seg_len[i]     = pad;
        seg_start[i+1] = s + size;
        seg_len[i+1]   = back;
      end else if (pad != 0) begin
        seg_len[i] = pad;
      end else if (back != 0) begin
        seg_start[i] = s + size;
        seg_len[i]   = back;
      end else begin
        close_slot(i);
      end
      g.status = ffa_pkg::ST_OK;
      g.offset = s;
      g.size   = size;
      return g;
    end
    g.status = ffa_pkg::ST_NO_FIT;
    return g;
  endfunction

  function automatic logic [1:0] release_block(logic [31:0] off, logic [31:0] size);
    int          p;
    logic        jp, jn;
    logic [31:0] blk_end;
    if (size == 0) return ffa_pkg::ST_OK;
    blk_end = off + size;
    p = 0;
    while (p < seg_count && seg_start[p] <= off) p++;
    jp = p > 0 && (seg_start[p-1] + seg_len[p-1]) == off;
    jn = p < seg_count && seg_start[p] == blk_end;
    if (jp && jn) begin
      seg_len[p-1] = seg_len[p-1] + size + seg_len[p];
      close_slot(p);
    end else if (jp) begin
      seg_len[p-1] = seg_len[p-1] + size;
    end else if (jn) begin
      seg_start[p] = off;
      seg_len[p]   = seg_len[p] + size;
    end else begin
      if (seg_count >= SEGS) return ffa_pkg::ST_FULL;
      open_slot(p);
      seg_start[p] = off;
      seg_len[p]   = size;
    end
    return ffa_pkg::ST_OK;
  endfunction

  function automatic grant_t predict_request(logic [1:0] mode, logic [31:0] size,
                                             logic [31:0] align, logic [31:0] off);
    grant_t g;
    block_t nb;
    g = '0;
    case (mode)
      ffa_pkg::MODE_ALLOC: begin
        g = first_fit(size, align);
        if (g.status == ffa_pkg::ST_OK && size != 0) begin
          nb = {g.offset, size};
          live_blocks.insert(live_blocks.size(), nb);
        end
      end
      ffa_pkg::MODE_FREE: g.status = release_block(off, size);
      ffa_pkg::MODE_WHOLE: begin
        seg_start[0] = region_base_q;
        seg_len[0]   = region_size_q;
        seg_count    = 1;
        live_blocks.delete();
      end
      default: ;
    endcase
    return g;
  endfunction

  // one request transaction
  task automatic send_request(logic [1:0] mode, logic [31:0] size, logic [31:0] align,
                              logic [31:0] off);
    int     gap;
    grant_t g;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {off, align, size};
    s_axis_tuser  = mode;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    g = predict_request(mode, size, align, off);
    expected_grants.insert(expected_grants.size(), g);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (expected_grants.size() != 0) @(negedge clk_i);
    repeat (3000) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_BASE) region_base_q = value;
    else region_size_q = value;
  endtask

  task automatic set_region(logic [31:0] base, logic [31:0] size);
    wait_idle();
    write_reg(ADDR_BASE, base);
    write_reg(ADDR_SIZE, size);
    send_request(ffa_pkg::MODE_WHOLE, $urandom, $urandom, $urandom);
  endtask

  task automatic test_directed();
    block_t b;
    set_region(32'h100, 32'h100);
    send_request(ffa_pkg::MODE_ALLOC, 32'h101, 1, 0);       // larger than region
    send_request(ffa_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 1, 0);
    send_request(ffa_pkg::MODE_ALLOC, 0, 0, 0);              // zero size, zero alignment
    send_request(ffa_pkg::MODE_ALLOC, 32'h10, 32'h30, 0);    // front and back split
    send_request(ffa_pkg::MODE_ALLOC, 32'h8, 32'h40, 0);
    send_request(ffa_pkg::MODE_ALLOC, 1, 32'h8000_0000, 0);  // no fit
    send_request(ffa_pkg::MODE_ALLOC, 1, 32'hFFFF_FFFF, 0);
    send_request(ffa_pkg::MODE_FREE, 0, 0, 32'h120);         // zero-size free
    send_request(ffa_pkg::MODE_FREE, 32'h10, 0, 32'h120);    // merge with both sides
    send_request(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ffa_pkg::MODE_WHOLE, 0, 0, 0);
    send_request(ffa_pkg::MODE_ALLOC, 32'h100, 1, 0);        // exact fit empties the list
    send_request(ffa_pkg::MODE_ALLOC, 0, 1, 0);              // empty list
    send_request(ffa_pkg::MODE_FREE, 32'h80, 0, 32'h180);    // into empty list
    send_request(ffa_pkg::MODE_FREE, 32'h40, 0, 32'h100);    // no neighbor
    send_request(ffa_pkg::MODE_FREE, 32'h40, 0, 32'h140);    // joins both
    send_request(ffa_pkg::MODE_ALLOC, 32'h100, 32'h100, 0);
    set_region(32'hFFFF_FF80, 32'hFFFF_FFFF);                // wrapping range
    send_request(ffa_pkg::MODE_ALLOC, 32'h90, 32'h10, 0);
    send_request(ffa_pkg::MODE_ALLOC, 32'h20, 32'h8000_0000, 0);
    while (live_blocks.size() != 0) begin
      b = live_blocks.pop_front();
      send_request(ffa_pkg::MODE_FREE, b.size, 0, b.offset);
    end
  endtask

  task automatic test_store_full();
    set_region(0, 0);
    wait_idle();
    write_reg(ADDR_SIZE, 32'hFFFF_FFFF);
    for (int k = 1; k <= SEGS; k++) send_request(ffa_pkg::MODE_FREE, 4, 0, 10 * k);
    send_request(ffa_pkg::MODE_FREE, 4, 0, 32'h1000);        // no room, block dropped
    send_request(ffa_pkg::MODE_ALLOC, 1, 4, 0);              // split with no room
    send_request(ffa_pkg::MODE_ALLOC, 4, 2, 0);              // exact fit still works
    send_request(ffa_pkg::MODE_FREE, 2, 0, 32'h2000);
  endtask

  task automatic test_random_phase(logic [31:0] base, logic [31:0] size, int count);
    int          r, idx;
    logic [31:0] cap, sz, al;
    block_t      b;
    set_region(base, size);
    cap = (size > 64) ? 32'd64 : size;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, cap);
        case ($urandom_range(0, 9))
          0:       al = 0;
          1:       al = $urandom;
          2:       al = 32'h8000_0000;
          3:       al = $urandom_range(1, 100);
          default: al = 32'd1 << $urandom_range(0, 7);
        endcase
        send_request(ffa_pkg::MODE_ALLOC, sz, al, $urandom);
      end else if (r < 92 && live_blocks.size() != 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        b = live_blocks[idx];
        live_blocks.delete(idx);
        send_request(ffa_pkg::MODE_FREE, b.size, $urandom, b.offset);
      end else if (r < 96) begin
        send_request(ffa_pkg::MODE_FREE,
                     $urandom_range(0, 9) ? $urandom_range(0, 16) : $urandom,
                     $urandom, base + $urandom_range(0, cap));
      end else if (r < 98) begin
        send_request(ffa_pkg::MODE_WHOLE, $urandom, $urandom, $urandom);
      end else begin
        send_request(MODE_UNUSED, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    region_base_q = '0;
    region_size_q = '0;
    seg_start[0] = '0;
    seg_len[0]   = '0;
    seg_count    = 1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_store_full();
    test_random_phase(32'h0, 32'h100, 300);
    test_random_phase(32'h1000, 32'h400, 300);
    test_random_phase(32'hFFFF_FF00, 32'h180, 250);
    test_random_phase($urandom, $urandom_range(1, 32'h800), 250);
    test_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 200);
    test_random_phase(32'h0, 32'h40, 200);

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ first_fit_aligned_free_list_allocator_top.f @@
rtl/ffa_pkg.sv
rtl/ffa_rem.sv
rtl/ffa_datapath.sv
rtl/ffa_ctrl.sv
rtl/first_fit_aligned_free_list_allocator_top.sv
tb/first_fit_aligned_free_list_allocator_top_tb.sv
